// ----- hdl/bsra_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsra_pkg
// Shared types and constants for the bit store with range-any query.
// ----------------------------------------------------------------------------
package bsra_pkg;

   localparam int OP_W  = 2;
   localparam int IDX_W = 12;
   localparam int END_W = 13;
   localparam int CNT_W = 13;

   typedef enum logic [OP_W-1:0] {
      OP_CLEAR = 2'd0,
      OP_GET   = 2'd1,
      OP_SET   = 2'd2,
      OP_ANY   = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      ST_INIT,
      ST_IDLE,
      ST_WALK,
      ST_FLUSH
   } state_type;

   typedef struct packed {
      logic load;
      logic step;
      logic init_step;
      logic finish;
   } bsra_cmd_type;

   typedef struct packed {
      logic last;
   } bsra_stat_type;

endpackage

// ----- hdl/bsra_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsra_ctrl
// Sequencer: clearing pass after reset, then one word walk per command.
// ----------------------------------------------------------------------------
module bsra_ctrl
   import bsra_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   output logic          busy,
   input  bsra_stat_type stat,
   output bsra_cmd_type  cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_INIT: begin
            if (stat.last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (start) state_in = ST_WALK;
         end
         ST_WALK: begin
            if (stat.last) state_in = ST_FLUSH;
         end
         ST_FLUSH: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_INIT;
         end
      endcase
   end

   always_comb begin
      cmd  = '0;
      busy = 1'b1;
      case (state_ff)
         ST_INIT: begin
            cmd.init_step = 1'b1;
         end
         ST_IDLE: begin
            busy     = 1'b0;
            cmd.load = start;
         end
         ST_WALK: begin
            cmd.step = 1'b1;
         end
         ST_FLUSH: begin
            cmd.finish = 1'b1;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

// ----- hdl/bsra_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsra_datapath
// Word store, address/base walker, edge-mask stage and response registers.
// ----------------------------------------------------------------------------
module bsra_datapath
   import bsra_pkg::*;
#(
   parameter int WORD_BITS = 64,
   parameter int WORDS     = 64
)
(
   input  logic             clock,
   input  logic             reset,
   input  bsra_cmd_type     cmd,
   output bsra_stat_type    stat,
   input  logic [OP_W-1:0]  req_opcode,
   input  logic [IDX_W-1:0] req_bit_index,
   input  logic             req_bit_value,
   input  logic [END_W-1:0] req_range_end,
   input  logic [CNT_W-1:0] req_bit_count,
   output logic             rsp_valid,
   output logic             rsp_answer_bit,
   output logic             rsp_answer_kind
);

   localparam int CAP   = WORDS * WORD_BITS;
   localparam int CAP_W = $clog2(CAP + 1);
   localparam int CW    = ((CAP_W > END_W) ? CAP_W : END_W) + 1;
   localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
   localparam int LW    = $clog2(WORD_BITS + 1);

   logic [WORD_BITS-1:0] mem [WORDS];

   opcode_type           op_ff, op_in;
   logic [IDX_W-1:0]     idx_ff, idx_in;
   logic                 val_ff, val_in;
   logic [CW-1:0]        end_ff, end_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [AW-1:0]        rd_addr_ff, rd_addr_in;
   logic [CW-1:0]        rd_base_ff, rd_base_in;
   logic                 s_vld_ff, s_vld_in;
   logic [AW-1:0]        s_addr_ff, s_addr_in;
   logic [CW-1:0]        s_base_ff, s_base_in;
   logic [WORD_BITS-1:0] rdata_ff;
   logic                 hit_ff, hit_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_bit_ff, rsp_bit_in;
   logic                 rsp_kind_ff, rsp_kind_in;

   logic [CW-1:0]        end_raw;
   logic [CW-1:0]        start_w;
   logic [CW-1:0]        lo_diff, hi_diff;
   logic [LW-1:0]        lo, hi;
   logic [WORD_BITS-1:0] mask;
   logic                 answering;
   logic                 word_hit;
   logic                 wr_en;
   logic [AW-1:0]        wr_addr;
   logic [WORD_BITS-1:0] wr_data;

   // load: latch the command word, clamp the range end to capacity
   always_comb begin
      if (opcode_type'(req_opcode) == OP_ANY) begin
         end_raw = CW'(req_range_end);
      end else begin
         end_raw = CW'(req_bit_index) + CW'(1);
      end
      if (end_raw > CW'(CAP)) begin
         end_raw = CW'(CAP);
      end
   end

   // edge masks for the word in the stage
   always_comb begin
      start_w = CW'(idx_ff);
      lo_diff = (start_w > s_base_ff) ? start_w - s_base_ff : '0;
      hi_diff = (end_ff > s_base_ff) ? end_ff - s_base_ff : '0;
      lo = (lo_diff >= CW'(WORD_BITS)) ? LW'(WORD_BITS) : lo_diff[LW-1:0];
      hi = (hi_diff >= CW'(WORD_BITS)) ? LW'(WORD_BITS) : hi_diff[LW-1:0];
      for (int k = 0; k < WORD_BITS; k++) begin
         mask[k] = (LW'(k) >= lo) && (LW'(k) < hi);
      end
      answering = (op_ff == OP_GET) || (op_ff == OP_ANY);
      word_hit  = s_vld_ff && answering && ((rdata_ff & mask) != '0);
   end

   // single write port: clearing pass, or stage write-back
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = s_addr_ff;
      wr_data = '0;
      if (cmd.init_step) begin
         wr_en   = 1'b1;
         wr_addr = rd_addr_ff;
      end else if (s_vld_ff) begin
         case (op_ff)
            OP_CLEAR: begin
               wr_en = (s_base_ff < CW'(cnt_ff));
            end
            OP_SET: begin
               wr_en   = 1'b1;
               wr_data = (rdata_ff & ~mask) | (val_ff ? mask : '0);
            end
            default: begin
               wr_en = 1'b0;
            end
         endcase
      end
   end

   always_comb begin
      op_in        = op_ff;
      idx_in       = idx_ff;
      val_in       = val_ff;
      end_in       = end_ff;
      cnt_in       = cnt_ff;
      rd_addr_in   = rd_addr_ff;
      rd_base_in   = rd_base_ff;
      s_vld_in     = cmd.step;
      s_addr_in    = rd_addr_ff;
      s_base_in    = rd_base_ff;
      hit_in       = hit_ff | word_hit;
      rsp_valid_in = cmd.finish && answering;
      rsp_bit_in   = rsp_bit_ff;
      rsp_kind_in  = rsp_kind_ff;
      if (cmd.load) begin
         op_in      = opcode_type'(req_opcode);
         idx_in     = req_bit_index;
         val_in     = req_bit_value;
         end_in     = end_raw;
         cnt_in     = req_bit_count;
         rd_addr_in = '0;
         rd_base_in = '0;
         hit_in     = 1'b0;
      end else if (cmd.step || cmd.init_step) begin
         rd_addr_in = rd_addr_ff + AW'(1);
         rd_base_in = rd_base_ff + CW'(WORD_BITS);
      end
      if (cmd.finish) begin
         rsp_bit_in  = hit_ff | word_hit;
         rsp_kind_in = (op_ff == OP_ANY);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_addr_ff   <= '0;
         s_vld_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         hit_ff       <= 1'b0;
      end else begin
         rd_addr_ff   <= rd_addr_in;
         s_vld_ff     <= s_vld_in;
         rsp_valid_ff <= rsp_valid_in;
         hit_ff       <= hit_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      idx_ff      <= idx_in;
      val_ff      <= val_in;
      end_ff      <= end_in;
      cnt_ff      <= cnt_in;
      rd_base_ff  <= rd_base_in;
      s_addr_ff   <= s_addr_in;
      s_base_ff   <= s_base_in;
      rsp_bit_ff  <= rsp_bit_in;
      rsp_kind_ff <= rsp_kind_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rdata_ff <= mem[rd_addr_ff];
   end

   assign stat.last       = (rd_addr_ff == AW'(WORDS - 1));
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_answer_bit  = rsp_bit_ff;
   assign rsp_answer_kind = rsp_kind_ff;

endmodule

// ----- hdl/bitset_store_range_any_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitset_store_range_any_top
// Bit store of WORDS x WORD_BITS with clear, get, set and range-any commands.
// Every command walks all WORDS words through one memory read port, one per
// cycle, then passes through a flush state: a new command is accepted only
// in idle, and the get/any answer strobe is registered from the flush state.
// The receiver cannot stall. After reset a clearing pass over all WORDS words
// zeroes the store; busy is high.
// ----------------------------------------------------------------------------
module bitset_store_range_any_top
   import bsra_pkg::*;
#(
   parameter int WORD_BITS = 64,
   parameter int WORDS     = 64
)
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  logic [OP_W-1:0]  req_opcode,
   input  logic [IDX_W-1:0] req_bit_index,
   input  logic             req_bit_value,
   input  logic [END_W-1:0] req_range_end,
   input  logic [CNT_W-1:0] req_bit_count,
   output logic             rsp_valid,
   output logic             rsp_answer_bit,
   output logic             rsp_answer_kind
);

   bsra_cmd_type  cmd;
   bsra_stat_type stat;

   bsra_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .cmd   (cmd)
   );

   bsra_datapath #(
      .WORD_BITS (WORD_BITS),
      .WORDS     (WORDS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .req_opcode      (req_opcode),
      .req_bit_index   (req_bit_index),
      .req_bit_value   (req_bit_value),
      .req_range_end   (req_range_end),
      .req_bit_count   (req_bit_count),
      .rsp_valid       (rsp_valid),
      .rsp_answer_bit  (rsp_answer_bit),
      .rsp_answer_kind (rsp_answer_kind)
   );

endmodule
